// ----- rtl/frr_pkg.sv -----
`default_nettype none

package frr_pkg;

  localparam int MAX_PAYLOAD_DEF = 96;

  localparam logic [7:0] SOF_BYTE = 8'h7E;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DST     = 3'd1,
    PH_SRC     = 3'd2,
    PH_CMD     = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  rx_byte;
    logic [7:0]  expected_source;
    logic [7:0]  expected_command;
    logic [7:0]  capacity;
    logic [15:0] timeout_ticks;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [1:0] status;
    logic [6:0] length;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/frr_core.sv -----
`default_nettype none

module frr_core #(
  parameter int MAX_PAYLOAD = frr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire frr_pkg::item_t  item,
  input  wire logic [7:0]      master_id,
  output frr_pkg::result_t     res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  logic              active, active_next;
  frr_pkg::phase_t   phase, phase_next;
  logic [7:0]        hdr_destination, hdr_destination_next;
  logic [7:0]        hdr_source, hdr_source_next;
  logic [7:0]        hdr_command, hdr_command_next;
  logic [LEN_W-1:0]  hdr_length, hdr_length_next;
  logic [LEN_W-1:0]  payload_count, payload_count_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [15:0]       elapsed_ticks, elapsed_ticks_next;
  logic [7:0]        want_source, want_source_next;
  logic [7:0]        want_command, want_command_next;
  logic [7:0]        want_capacity, want_capacity_next;
  logic [15:0]       deadline, deadline_next;

  logic [7:0]        b;
  logic [15:0]       ticks_inc;
  logic              too_long;
  logic [LEN_W-1:0]  count_inc;

  assign b         = item.rx_byte;
  assign ticks_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign too_long  = ({1'b0, b} > 9'(MAX_PAYLOAD)) || (b > want_capacity);
  assign count_inc = payload_count + LEN_W'(1);

  always_comb begin
    active_next          = active;
    phase_next           = phase;
    hdr_destination_next = hdr_destination;
    hdr_source_next      = hdr_source;
    hdr_command_next     = hdr_command;
    hdr_length_next      = hdr_length;
    payload_count_next   = payload_count;
    running_xor_next     = running_xor;
    elapsed_ticks_next   = elapsed_ticks;
    want_source_next     = want_source;
    want_command_next    = want_command;
    want_capacity_next   = want_capacity;
    deadline_next        = deadline;
    res                  = '0;

    if (step) begin
      if (item.cmd == frr_pkg::CMD_START) begin
        want_source_next   = item.expected_source;
        want_command_next  = item.expected_command;
        want_capacity_next = item.capacity;
        deadline_next      = item.timeout_ticks;
        elapsed_ticks_next = '0;
        phase_next         = frr_pkg::PH_HUNT;
        payload_count_next = '0;
        running_xor_next   = '0;
        active_next        = 1'b1;
        if (item.timeout_ticks == 16'd0) begin
          active_next = 1'b0;
          res.valid   = 1'b1;
          res.kind    = frr_pkg::KIND_STATUS;
          res.status  = frr_pkg::ST_TIMEOUT;
        end
      end else if (active && item.cmd == frr_pkg::CMD_TICK) begin
        elapsed_ticks_next = ticks_inc;
        if (ticks_inc >= deadline) begin
          active_next = 1'b0;
          phase_next  = frr_pkg::PH_HUNT;
          res.valid   = 1'b1;
          res.kind    = frr_pkg::KIND_STATUS;
          res.status  = frr_pkg::ST_TIMEOUT;
        end
      end else if (active && item.cmd == frr_pkg::CMD_BYTE) begin
        case (phase)
          frr_pkg::PH_HUNT: begin
            if (b == frr_pkg::SOF_BYTE) begin
              running_xor_next   = '0;
              payload_count_next = '0;
              phase_next         = frr_pkg::PH_DST;
            end
          end
          frr_pkg::PH_DST: begin
            hdr_destination_next = b;
            running_xor_next     = running_xor ^ b;
            phase_next           = frr_pkg::PH_SRC;
          end
          frr_pkg::PH_SRC: begin
            hdr_source_next  = b;
            running_xor_next = running_xor ^ b;
            phase_next       = frr_pkg::PH_CMD;
          end
          frr_pkg::PH_CMD: begin
            hdr_command_next = b;
            running_xor_next = running_xor ^ b;
            phase_next       = frr_pkg::PH_LEN;
          end
          frr_pkg::PH_LEN: begin
            if (too_long) begin
              active_next = 1'b0;
              phase_next  = frr_pkg::PH_HUNT;
              res.valid   = 1'b1;
              res.kind    = frr_pkg::KIND_STATUS;
              res.status  = frr_pkg::ST_BADSIZE;
            end else begin
              // b is known to fit here after the size check
              hdr_length_next    = LEN_W'(b);
              running_xor_next   = running_xor ^ b;
              payload_count_next = '0;
              phase_next = (b == 8'd0) ? frr_pkg::PH_CHECK : frr_pkg::PH_PAYLOAD;
            end
          end
          frr_pkg::PH_PAYLOAD: begin
            res.valid          = 1'b1;
            res.kind           = frr_pkg::KIND_PAYLOAD;
            res.payload_byte   = b;
            res.byte_index     = 7'(payload_count);
            running_xor_next   = running_xor ^ b;
            payload_count_next = count_inc;
            if (count_inc >= hdr_length) begin
              phase_next = frr_pkg::PH_CHECK;
            end
          end
          frr_pkg::PH_CHECK: begin
            phase_next = frr_pkg::PH_HUNT;
            if (b == running_xor && hdr_destination == master_id &&
                hdr_source == want_source && hdr_command == want_command) begin
              active_next = 1'b0;
              res.valid   = 1'b1;
              res.kind    = frr_pkg::KIND_STATUS;
              res.status  = frr_pkg::ST_OK;
              res.length  = 7'(hdr_length);
            end
          end
          default: begin
            phase_next = frr_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      phase         <= frr_pkg::PH_HUNT;
      hdr_length    <= '0;
      payload_count <= '0;
      running_xor   <= '0;
      elapsed_ticks <= '0;
      want_capacity <= '0;
      deadline      <= '0;
    end else begin
      active        <= active_next;
      phase         <= phase_next;
      hdr_length    <= hdr_length_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
      elapsed_ticks <= elapsed_ticks_next;
      want_capacity <= want_capacity_next;
      deadline      <= deadline_next;
    end
  end

  // header and match fields, no reset needed
  always_ff @(posedge clk) begin
    hdr_destination <= hdr_destination_next;
    hdr_source      <= hdr_source_next;
    hdr_command     <= hdr_command_next;
    want_source     <= want_source_next;
    want_command    <= want_command_next;
  end

  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == frr_pkg::KIND_STATUS |=> !active)
    else $error("request still armed after final status");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !active && item.cmd != frr_pkg::CMD_START |-> !res.valid)
    else $error("result from idle block");

  a_phase_armed: assert property (@(posedge clk) disable iff (rst)
    phase != frr_pkg::PH_HUNT |-> active)
    else $error("frame parse in progress while idle");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == frr_pkg::KIND_PAYLOAD |-> phase == frr_pkg::PH_PAYLOAD && step)
    else $error("payload beat outside payload phase");

endmodule

`default_nettype wire

// ----- rtl/framed_response_receiver_top.sv -----
// Framed response receiver: start / byte / tick beats in, payload and status beats out.
// An input beat goes through the input register, then the core logic, then the result register.
// Throughput: one input beat per cycle while the output side keeps taking beats.
// A beat whose work gives no result still passes through the input register.
// Reset (rst, synchronous, active high) returns the block to idle with master_id 0.
`default_nettype none

module framed_response_receiver_top #(
  parameter int MAX_PAYLOAD = frr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // rx_byte, expected_source, expected_command,
                                     // capacity, timeout_ticks
  input  wire logic [1:0]  s_tuser,  // cmd
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // payload_byte, byte_index, status, length
  output logic             m_tuser,  // kind
  // master_id register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic              in_valid;
  frr_pkg::item_t    in_item;
  logic              advance;
  logic [7:0]        master_id;
  frr_pkg::result_t  res;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd              <= frr_pkg::cmd_t'(s_tuser);
      in_item.rx_byte          <= s_tdata[7:0];
      in_item.expected_source  <= s_tdata[15:8];
      in_item.expected_command <= s_tdata[23:16];
      in_item.capacity         <= s_tdata[31:24];
      in_item.timeout_ticks    <= s_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      master_id <= cfg_data;
    end
  end

  frr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .master_id (master_id),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tuser <= res.kind;
      m_tdata <= {res.length, res.status, res.byte_index, res.payload_byte};
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;

  localparam int ITEM_TARGET = 1150;
  localparam int NUM_PHASES  = 5;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [6:0] idx;
    logic [1:0] status;
    logic [6:0] len;
  } resp_beat_t;

  typedef enum int {
    END_OK,
    END_TIMEOUT,
    END_BADSIZE,
    END_ABANDON
  } ending_t;

  // Tracks the receiver's request state and the response beats it owes.
  class frame_scoreboard;
    logic [7:0]       master_id = 8'h00;
    bit               armed = 1'b0;
    frr_pkg::phase_t  ph = frr_pkg::PH_HUNT;
    logic [7:0]       dst = 8'h00, src = 8'h00, opc = 8'h00, xsum = 8'h00;
    logic [6:0]       plen = 7'd0, pcount = 7'd0;
    logic [15:0]      elapsed = 16'd0, deadline = 16'd0;
    logic [7:0]       want_src = 8'h00, want_opc = 8'h00, want_cap = 8'h00;
    resp_beat_t       pending[$];
    int               errors = 0, handled = 0;
    int               n_ok = 0, n_timeout = 0, n_badsize = 0, n_payload = 0;

    function void end_request(logic [1:0] st, logic [6:0] len);
      resp_beat_t o;
      o = '0;
      o.kind = frr_pkg::KIND_STATUS;
      o.status = st;
      o.len = len;
      armed = 1'b0;
      ph = frr_pkg::PH_HUNT;
      pending.push_back(o);
      if (st == frr_pkg::ST_OK) n_ok++;
      else if (st == frr_pkg::ST_TIMEOUT) n_timeout++;
      else n_badsize++;
    endfunction

    function void note_input(frr_pkg::cmd_t c, logic [47:0] d);
      logic [7:0] b;
      resp_beat_t o;
      b = d[7:0];
      if (c == frr_pkg::CMD_START) begin
        handled++;
        want_src = d[15:8];
        want_opc = d[23:16];
        want_cap = d[31:24];
        deadline = d[47:32];
        elapsed = 16'd0;
        ph = frr_pkg::PH_HUNT;
        pcount = 7'd0;
        xsum = 8'h00;
        armed = 1'b1;
        if (deadline == 16'd0) end_request(frr_pkg::ST_TIMEOUT, 7'd0);
        return;
      end
      if (!armed || c == frr_pkg::CMD_UNUSED) return;
      handled++;
      if (c == frr_pkg::CMD_TICK) begin
        if (elapsed != 16'hFFFF) elapsed++;
        if (elapsed >= deadline) end_request(frr_pkg::ST_TIMEOUT, 7'd0);
        return;
      end
      case (ph)
        frr_pkg::PH_HUNT: begin
          if (b == frr_pkg::SOF_BYTE) begin
            xsum = 8'h00;
            pcount = 7'd0;
            ph = frr_pkg::PH_DST;
          end
        end
        frr_pkg::PH_DST: begin
          dst = b;
          xsum ^= b;
          ph = frr_pkg::PH_SRC;
        end
        frr_pkg::PH_SRC: begin
          src = b;
          xsum ^= b;
          ph = frr_pkg::PH_CMD;
        end
        frr_pkg::PH_CMD: begin
          opc = b;
          xsum ^= b;
          ph = frr_pkg::PH_LEN;
        end
        frr_pkg::PH_LEN: begin
          // size is judged before any address match
          if (int'(b) > frr_pkg::MAX_PAYLOAD_DEF || b > want_cap) begin
            end_request(frr_pkg::ST_BADSIZE, 7'd0);
          end else begin
            plen = b[6:0];
            xsum ^= b;
            pcount = 7'd0;
            ph = (b == 8'd0) ? frr_pkg::PH_CHECK : frr_pkg::PH_PAYLOAD;
          end
        end
        frr_pkg::PH_PAYLOAD: begin
          o = '0;
          o.kind = frr_pkg::KIND_PAYLOAD;
          o.pbyte = b;
          o.idx = pcount;
          pending.push_back(o);
          n_payload++;
          xsum ^= b;
          pcount++;
          if (pcount >= plen) ph = frr_pkg::PH_CHECK;
        end
        frr_pkg::PH_CHECK: begin
          if (b == xsum && dst == master_id && src == want_src && opc == want_opc)
            end_request(frr_pkg::ST_OK, plen);
          else
            ph = frr_pkg::PH_HUNT;
        end
        default: ph = frr_pkg::PH_HUNT;
      endcase
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [23:0] d);
      resp_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: kind %0d data %h", kind, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("kind", int'(e.kind), int'(kind));
      compare_field("payload_byte", int'(e.pbyte), int'(d[7:0]));
      compare_field("byte_index", int'(e.idx), int'(d[14:8]));
      compare_field("status", int'(e.status), int'(d[16:15]));
      compare_field("length", int'(e.len), int'(d[23:17]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // rx_byte, expected_source, expected_command, capacity,
                               // timeout_ticks
  logic [1:0]  s_tuser = '0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // payload_byte, byte_index, status, length
  logic        m_tuser;        // kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  frame_scoreboard sb = new();

  bit gaps_on = 1'b0;
  int burst_left = 0;
  int stall_mode = 0;
  int tick_odds = 0;
  int rx_cycle = 0;
  int quiet_cycles = 0;

  framed_response_receiver_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    rx_cycle++;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ((rx_cycle % 11) < 7);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rnd_bits();
    logic [47:0] r;
    r[31:0] = $urandom;
    r[47:32] = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic int pick_len(int lim);
    if ($urandom_range(0, 19) == 0) return lim;
    return $urandom_range(0, (lim < 8) ? lim : 8);
  endfunction

  // random gap once the current burst is used up
  task automatic pace();
    int n;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    n = $urandom_range(1, 12);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
    burst_left = $urandom_range(0, 15);
  endtask

  task automatic drive_beat(frr_pkg::cmd_t c, logic [47:0] d);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(c, d);
    pace();
  endtask

  task automatic put_byte(logic [7:0] b);
    logic [47:0] d;
    if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
      drive_beat(frr_pkg::CMD_TICK, rnd_bits());
    if (tick_odds != 0 && $urandom_range(0, 63) == 0)
      drive_beat(frr_pkg::CMD_UNUSED, rnd_bits());
    d = rnd_bits();
    d[7:0] = b;
    drive_beat(frr_pkg::CMD_BYTE, d);
  endtask

  task automatic start_request(logic [7:0] src, logic [7:0] opc, logic [7:0] cap,
                               logic [15:0] to);
    logic [47:0] d;
    d = rnd_bits();
    d[15:8] = src;
    d[23:16] = opc;
    d[31:24] = cap;
    d[47:32] = to;
    drive_beat(frr_pkg::CMD_START, d);
  endtask

  task automatic send_header(logic [7:0] dst, logic [7:0] src, logic [7:0] opc,
                             logic [7:0] len);
    put_byte(frr_pkg::SOF_BYTE);
    put_byte(dst);
    put_byte(src);
    put_byte(opc);
    put_byte(len);
  endtask

  task automatic send_frame(logic [7:0] dst, logic [7:0] src, logic [7:0] opc,
                            logic [7:0] len, bit bad_sum);
    logic [7:0] x, b;
    x = dst ^ src ^ opc ^ len;
    send_header(dst, src, opc, len);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 15) == 0) ? frr_pkg::SOF_BYTE : 8'($urandom_range(0, 255));
      x ^= b;
      put_byte(b);
    end
    if (bad_sum) x ^= 8'($urandom_range(1, 255));
    put_byte(x);
  endtask

  task automatic run_request();
    ending_t     ending;
    int          r, nbad, lim;
    logic [7:0]  src, opc, cap, nz, b;
    logic [15:0] to;
    r = $urandom_range(0, 9);
    ending = (r < 5) ? END_OK : (r < 7) ? END_TIMEOUT : (r < 9) ? END_BADSIZE : END_ABANDON;
    src = 8'($urandom_range(0, 255));
    opc = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) src = frr_pkg::SOF_BYTE;
    case ($urandom_range(0, 7))
      0: cap = 8'd0;
      1: cap = 8'hFF;
      2: cap = 8'(frr_pkg::MAX_PAYLOAD_DEF);
      default: cap = 8'($urandom_range(0, 255));
    endcase
    lim = (int'(cap) < frr_pkg::MAX_PAYLOAD_DEF) ? int'(cap) : frr_pkg::MAX_PAYLOAD_DEF;
    if (ending == END_TIMEOUT) to = 16'($urandom_range(1, 12));
    else if ($urandom_range(0, 19) == 0) to = 16'hFFFF;
    else to = 16'($urandom_range(200, 3000));
    if ($urandom_range(0, 39) == 0) to = 16'd0;
    start_request(src, opc, cap, to);

    // frames that must be dropped before the one that decides the outcome
    nbad = $urandom_range(0, 2);
    for (int i = 0; i < nbad; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom_range(0, 255));
        put_byte((b == frr_pkg::SOF_BYTE) ? 8'h00 : b);
      end
      nz = 8'($urandom_range(1, 255));
      case ($urandom_range(0, 4))
        0: send_frame(sb.master_id ^ nz, src, opc, 8'(pick_len(lim)), 1'b0);
        1: send_frame(sb.master_id, src ^ nz, opc, 8'(pick_len(lim)), 1'b0);
        2: send_frame(sb.master_id, src, opc ^ nz, 8'(pick_len(lim)), 1'b0);
        3: send_frame(sb.master_id, src, opc, 8'(pick_len(lim)), 1'b1);
        default: send_frame(sb.master_id ^ nz, src, opc, 8'(pick_len(lim)), 1'b1);
      endcase
    end

    case (ending)
      END_OK: send_frame(sb.master_id, src, opc, 8'(pick_len(lim)), 1'b0);
      END_TIMEOUT: repeat (to) drive_beat(frr_pkg::CMD_TICK, rnd_bits());
      END_BADSIZE: begin
        b = ($urandom_range(0, 1) == 0) ? sb.master_id : 8'($urandom_range(0, 255));
        send_header(b, src, opc, 8'($urandom_range(lim + 1, 255)));
      end
      default: begin
        // partial frame, left hanging for the next start
        send_header(sb.master_id, src, opc, 8'(pick_len(lim)));
        put_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_master_id(logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.master_id = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int base;
    bit phase_gaps[NUM_PHASES];
    int phase_stall[NUM_PHASES];
    logic [7:0] phase_id[NUM_PHASES];
    phase_gaps = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_stall = '{1, 2, 0, 0, 1};
    phase_id = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), frr_pkg::SOF_BYTE,
                 8'($urandom_range(0, 255))};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle block, zero deadline, drop then accept, size limits, restart
    stall_mode = 1;
    drive_beat(frr_pkg::CMD_BYTE, 48'h7E);
    drive_beat(frr_pkg::CMD_TICK, rnd_bits());
    drive_beat(frr_pkg::CMD_UNUSED, rnd_bits());
    write_master_id(8'h5A);
    start_request(8'h11, 8'h22, 8'hFF, 16'd0);
    start_request(8'h11, 8'h22, 8'hFF, 16'hFFFF);
    send_frame(8'h5A, 8'h11, 8'h22, 8'd1, 1'b1);
    send_frame(8'h5A, 8'h11, 8'h22, 8'd0, 1'b0);
    start_request(8'h11, 8'h22, 8'h00, 16'd2);
    drive_beat(frr_pkg::CMD_TICK, rnd_bits());
    send_header(8'h5A, 8'h11, 8'h22, 8'd1);
    start_request(8'h11, 8'h22, 8'hFF, 16'hFFFF);
    start_request(8'h11, 8'h22, 8'hFF, 16'd3);
    send_header(8'h00, 8'h00, 8'h00, 8'(frr_pkg::MAX_PAYLOAD_DEF + 1));

    base = sb.handled;
    tick_odds = 16;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_master_id(phase_id[p]);
      gaps_on = phase_gaps[p];
      stall_mode = phase_stall[p];
      while (sb.handled - base < (p + 1) * ITEM_TARGET / NUM_PHASES) run_request();
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("%0d beats acted on; %0d payload bytes, %0d frames ok,",
             sb.handled, sb.n_payload, sb.n_ok);
    $display("%0d timeouts, %0d size errors; node addresses, gaps and stalls varied",
             sb.n_timeout, sb.n_badsize);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
